FILE: sv/dcd_pkg.sv
// dcd_pkg: types, constants and the month-length table for the day count converter
// no dependencies
`default_nettype none

package dcd_pkg;

    // epoch and field widths
    localparam int EPOCH_YEAR = 1970;
    localparam int YEAR_W     = 12;
    localparam int COUNT_W    = 16;

    // epoch split for the leap rule: year mod 100 and (year / 100) mod 4
    localparam logic [6:0] EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
    localparam logic [1:0] EPOCH_CENT4  = 2'((EPOCH_YEAR / 100) % 4);
    localparam logic [YEAR_W-1:0] EPOCH_YEAR_V = YEAR_W'(EPOCH_YEAR);

    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [6:0] LAST_MOD100 = 7'd99;

    // month index runs 0..11
    localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [3:0] LAST_MONTH      = 4'd11;
    localparam logic [3:0] FEBRUARY        = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MON_WALK
    } dcd_state_t;

    typedef struct packed {
        logic [15:0] day_count;
        logic [7:0]  hour_weekday_byte;
        logic [5:0]  minutes_in;
        logic [5:0]  seconds_in;
    } dcd_in_t;

    typedef struct packed {
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [2:0]  weekday_out;
        logic [5:0]  minutes_out;
        logic [5:0]  seconds_out;
    } dcd_out_t;

    // days in month, february lengthened in leap years
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
            FEBRUARY:                                  len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: sv/day_count_to_calendar_date.sv
// day_count_to_calendar_date: converts a day count since the epoch into year, month, day
// depends on dcd_pkg
// an item passes from accept through ST_YEAR and ST_MON_WALK into the output register;
// a new item is accepted only after the last one is loaded into the output register;
// the shared subtractor walks one year or month per cycle
// a waiting result holds the conversion at its last step, and the input stays not ready,
// until the output register frees
// reset (aresetn, synchronous, active low) returns to idle and drops m_valid
`default_nettype none

module day_count_to_calendar_date import dcd_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dcd_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output dcd_out_t      m_data
);

    dcd_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] rem_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [6:0]         mod100_reg;
    logic [1:0]         cent_reg;
    logic [3:0]         month_reg;
    dcd_in_t            in_reg;
    dcd_out_t           out_reg;
    logic               m_valid_reg;

    logic               leap;
    logic [8:0]         sub;
    logic [COUNT_W:0]   diff;
    logic               fits;
    logic               year_step;
    logic               month_step;
    logic               out_free;
    logic               load_out;
    logic               accept;
    logic [3:0]         month_clamped;

    // leap rule from the tracked year fields
    assign leap = (year_reg[1:0] == 2'd0) && ((mod100_reg != 7'd0) || (cent_reg == 2'd0));

    // shared subtract and compare unit
    always_comb begin
        unique case (state_reg)
            ST_YEAR:     sub = leap ? DAYS_LEAP : DAYS_COMMON;
            ST_MON_WALK: sub = {4'd0, month_len(month_reg, leap)};
            default:     sub = 9'd0;
        endcase
        diff = {1'b0, rem_reg} - {{(COUNT_W - 8){1'b0}}, sub};
        fits = !diff[COUNT_W];
    end

    // step and handshake controls
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        accept     = s_valid && s_ready;
        out_free   = !m_valid_reg || m_ready;
        year_step  = (state_reg == ST_YEAR) && fits;
        month_step = (state_reg == ST_MON_WALK) && fits && (month_reg < MONTHS_PER_YEAR);
        load_out   = (state_reg == ST_MON_WALK) && !month_step && out_free;
        m_valid    = m_valid_reg;
        m_data     = out_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) begin
                             state_next = ST_YEAR;
                         end
            ST_YEAR:     if (!year_step) begin
                             state_next = ST_MON_WALK;
                         end
            ST_MON_WALK: if (load_out) begin
                             state_next = ST_IDLE;
                         end
            default:     state_next = ST_IDLE;
        endcase
    end

    assign month_clamped = (month_reg > LAST_MONTH) ? LAST_MONTH : month_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg     <= s_data;
            rem_reg    <= s_data.day_count;
            year_reg   <= EPOCH_YEAR_V;
            mod100_reg <= EPOCH_MOD100;
            cent_reg   <= EPOCH_CENT4;
            month_reg  <= 4'd0;
        end else if (year_step) begin
            rem_reg  <= diff[COUNT_W-1:0];
            year_reg <= year_reg + 1'b1;
            if (mod100_reg == LAST_MOD100) begin
                mod100_reg <= 7'd0;
                cent_reg   <= cent_reg + 1'b1;
            end else begin
                mod100_reg <= mod100_reg + 1'b1;
            end
        end else if (month_step) begin
            rem_reg   <= diff[COUNT_W-1:0];
            month_reg <= month_reg + 1'b1;
        end

        // result item
        if (load_out) begin
            out_reg.year_out    <= year_reg;
            out_reg.month_out   <= month_clamped + 1'b1;
            out_reg.day_out     <= rem_reg[4:0] + 1'b1;
            out_reg.hour_out    <= in_reg.hour_weekday_byte[4:0];
            out_reg.weekday_out <= in_reg.hour_weekday_byte[7:5];
            out_reg.minutes_out <= in_reg.minutes_in;
            out_reg.seconds_out <= in_reg.seconds_in;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/dcd_date_checker.sv
// dcd_date_checker: watches both channels of the day count converter, predicts each date
// and compares it field by field against the result channel; depends on dcd_pkg
module dcd_date_checker import dcd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  dcd_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  dcd_out_t m_data,
    output int       fail_count,
    output int       dates_waiting,
    output int       dates_checked,
    output int       year_lo,
    output int       year_hi
);

    localparam int MAX_REPORTS = 10;
    localparam int unsigned SHORTEST_MONTH = 28;

    // month lengths, january at index 0
    localparam logic [11:0][4:0] MONTH_DAYS = {
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
        5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31
    };

    dcd_out_t dates_due[$];
    int failures = 0;
    int checked = 0;
    int waiting = 0;
    int lo_year = 4095;
    int hi_year = 0;

    assign fail_count    = failures;
    assign dates_waiting = waiting;
    assign dates_checked = checked;
    assign year_lo       = lo_year;
    assign year_hi       = hi_year;

    // gregorian rule: every 4th year, centuries only when divisible by 400
    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // walk whole years, then whole months, off the day count
    function automatic dcd_out_t civil_date_of(input dcd_in_t snap);
        dcd_out_t date;
        int unsigned rest;
        int unsigned yr;
        int unsigned mon;
        int unsigned len;
        bit ly;
        rest = snap.day_count;
        yr   = EPOCH_YEAR;
        mon  = 0;
        while (rest >= DAYS_COMMON) begin
            if (leap_year(yr)) begin
                // day 365 of a leap year is still 31 december
                if (rest < DAYS_LEAP) break;
                rest -= DAYS_LEAP;
            end else begin
                rest -= DAYS_COMMON;
            end
            yr++;
        end
        ly = leap_year(yr);
        while (mon < MONTHS_PER_YEAR && rest >= SHORTEST_MONTH) begin
            len = MONTH_DAYS[mon];
            if (ly && mon == FEBRUARY) len = 29;
            if (rest < len) break;
            rest -= len;
            mon++;
        end
        if (mon > LAST_MONTH) mon = LAST_MONTH;
        date.year_out    = 12'(yr);
        date.month_out   = 4'(mon + 1);
        date.day_out     = 5'(rest + 1);
        date.hour_out    = snap.hour_weekday_byte[4:0];
        date.weekday_out = snap.hour_weekday_byte[7:5];
        date.minutes_out = snap.minutes_in;
        date.seconds_out = snap.seconds_in;
        return date;
    endfunction

    function automatic string date_text(input dcd_out_t d);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d weekday %0d", d.year_out, d.month_out,
                         d.day_out, d.hour_out, d.minutes_out, d.seconds_out, d.weekday_out);
    endfunction

    // results are retired before new items are queued; a result can be taken in the same cycle as the next accept
    always @(posedge aclk) begin : watch
        dcd_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                checked++;
                if (int'(m_data.year_out) < lo_year) lo_year = m_data.year_out;
                if (int'(m_data.year_out) > hi_year) hi_year = m_data.year_out;
                if (dates_due.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("date result with no item pending: %s", date_text(m_data));
                end else begin
                    want = dates_due.pop_front();
                    if (m_data.year_out    !== want.year_out    ||
                        m_data.month_out   !== want.month_out   ||
                        m_data.day_out     !== want.day_out     ||
                        m_data.hour_out    !== want.hour_out    ||
                        m_data.weekday_out !== want.weekday_out ||
                        m_data.minutes_out !== want.minutes_out ||
                        m_data.seconds_out !== want.seconds_out) begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display("date mismatch at %0t: expected %s, got %s",
                                     $realtime, date_text(want), date_text(m_data));
                    end
                end
            end
            if (s_valid && s_ready) dates_due.push_back(civil_date_of(s_data));
            waiting = dates_due.size();
        end
    end

endmodule

FILE: tb/sv/tb_day_count_to_calendar_date.sv
// tb_day_count_to_calendar_date: drives day count snapshots into the converter and gives
// the verdict; depends on dcd_pkg, day_count_to_calendar_date and dcd_date_checker
module tb_day_count_to_calendar_date;
    import dcd_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 250;
    localparam int NUM_MARKS    = 17;

    // calendar landmarks: year ends, leap days, 2000 (leap century), 2100 (common century)
    localparam logic [NUM_MARKS-1:0][15:0] LANDMARKS = {
        16'd0,     16'd364,   16'd365,   16'd730,   16'd788,   16'd789,
        16'd790,   16'd1095,  16'd1096,  16'd10957, 16'd11016, 16'd11322,
        16'd47482, 16'd47541, 16'd47846, 16'd65534, 16'd65535
    };

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    dcd_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    dcd_out_t m_data;

    int fail_count;
    int dates_waiting;
    int dates_checked;
    int year_lo;
    int year_hi;

    bit calm = 1'b0;
    bit hold_request = 1'b0;

    day_count_to_calendar_date dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    dcd_date_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .dates_waiting (dates_waiting),
        .dates_checked (dates_checked),
        .year_lo       (year_lo),
        .year_hi       (year_hi)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("day_count_to_calendar_date regression: fail");
        $finish;
    end

    // offer one snapshot, with an occasional idle gap ahead of it
    task automatic offer_snapshot(input logic [15:0] days, input logic [7:0] hw,
                                  input logic [5:0] mins, input logic [5:0] secs);
        if (!calm && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{day_count: days, hour_weekday_byte: hw, minutes_in: mins,
                     seconds_in: secs};
        do @(posedge aclk); while (!s_ready);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // reset, directed landmarks, random snapshots, drain and verdict
    initial begin
        int n;
        int k;
        int unsigned pick;
        logic [15:0] days;
        logic [7:0] hw;
        logic [5:0] mins;
        logic [5:0] secs;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // landmarks with time fields at their edges and out of range
        for (n = 0; n < NUM_MARKS; n++) begin
            case (n % 5)
                0: hw = 8'h00;
                1: hw = 8'hFF;
                2: hw = 8'h1F;
                3: hw = 8'hE0;
                default: hw = 8'h18;
            endcase
            case (n % 4)
                0: mins = 6'd0;
                1: mins = 6'd59;
                2: mins = 6'd60;
                default: mins = 6'd63;
            endcase
            secs = 6'd63 - mins;
            offer_snapshot(LANDMARKS[n], hw, mins, secs);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 800 && n < 1100);
            if (n == 300) hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                k = $urandom_range(0, NUM_MARKS - 1);
                days = LANDMARKS[k] + 16'($urandom_range(0, 4)) - 16'd2;
            end else if (pick < 40) begin
                days = 16'($urandom_range(0, 1500));
            end else begin
                days = 16'($urandom);
            end
            hw = 8'($urandom);
            mins = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                               : 6'($urandom_range(0, 59));
            secs = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                               : 6'($urandom_range(0, 59));
            offer_snapshot(days, hw, mins, secs);
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // let the checker queue the last item before waiting on it
        @(posedge aclk);
        wait (dates_waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d date conversions, years %0d through %0d", dates_checked,
                 year_lo, year_hi);
        $display("calendar landmarks, full-range counts, out-of-range time fields, long stall");
        if (fail_count == 0 && dates_waiting == 0) begin
            $display("day_count_to_calendar_date regression: pass");
        end else begin
            $display("day_count_to_calendar_date regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/dcd_pkg.sv
sv/day_count_to_calendar_date.sv
tb/sv/dcd_date_checker.sv
tb/sv/tb_day_count_to_calendar_date.sv
